// ===== src/scpr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the second-chance page replacer.
// Used by the controller, the datapath and the top level.
package scpr_pkg;

    localparam int unsigned PAGE_W    = 16;  // page number field width
    localparam int unsigned IDX_W     = 4;   // frame index field width
    localparam int unsigned MISS_W    = 16;  // miss counter width
    localparam int unsigned CFG_W     = 5;   // frames_in_use register width
    localparam int unsigned APB_DW    = 32;  // configuration data width
    localparam int unsigned APB_AW    = 2;   // configuration address width

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [MISS_W-1:0] MISS_MAX  = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the page of an accepted beat, restart the scan
        logic scan;          // issue the next lookup read and advance the scan
        logic hit_commit;    // set the reference bit of the matching frame
        logic fill_commit;   // write the page into the next empty frame
        logic sweep_start;   // bring the clock hand back into range
        logic sweep;         // clear the reference bit under the hand and advance
        logic victim_read;   // read the page held in the victim frame
        logic evict_commit;  // replace the victim and advance the hand
        logic out_load;      // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;         // the compared frame holds the requested page
        logic scan_end;      // every valid frame has been compared without a match
        logic fill_room;     // an empty frame is still available
        logic ref_set;       // reference bit under the clock hand is set
    } t_dp_sts;

endpackage

// ===== src/scpr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the second-chance page replacer: frame page memory, reference
// bits, fill count, clock hand, miss counter and result registers. Uses scpr_pkg.
module scpr_datapath #(
    parameter int unsigned FRAMES    = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scpr_pkg::t_dp_cmd             i_cmd,
    output scpr_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [scpr_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic [scpr_pkg::CFG_W-1:0]    o_cfg,
    input  logic [scpr_pkg::PAGE_W-1:0]   i_page_number,
    output logic                          o_hit,
    output logic [scpr_pkg::IDX_W-1:0]    o_frame_index,
    output logic                          o_evicted_valid,
    output logic [scpr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [scpr_pkg::MISS_W-1:0]   o_miss_count
);
    import scpr_pkg::*;

    localparam int unsigned FIDX_W = $clog2(FRAMES);
    localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
    localparam int unsigned CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [PAGE_BITS-1:0] mem [FRAMES];

    logic [CFG_W-1:0]     r_cfg;
    logic [FRAMES-1:0]    r_ref;
    logic [CNT_W-1:0]     r_fill;
    logic [FIDX_W-1:0]    r_hand;
    logic [MISS_W-1:0]    r_misses;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_scan;
    logic                 r_cmp_vld;
    logic [FIDX_W-1:0]    r_cmp_idx;
    logic [PAGE_BITS-1:0] r_rd_data;

    logic                 r_res_hit;
    logic [FIDX_W-1:0]    r_res_idx;
    logic                 r_res_ev;
    logic [PAGE_BITS-1:0] r_res_evp;

    logic                 r_o_hit;
    logic [IDX_W-1:0]     r_o_idx;
    logic                 r_o_ev;
    logic [PAGE_W-1:0]    r_o_evp;
    logic [MISS_W-1:0]    r_o_miss;

    logic [CMP_W-1:0]     cfg_wide;
    logic [CNT_W-1:0]     active;
    logic [CNT_W-1:0]     scan_lim;
    logic [FIDX_W-1:0]    hand_inc;
    logic [MISS_W-1:0]    misses_inc;
    logic                 rd_en;
    logic [FIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [FIDX_W-1:0]    wr_addr;

    // The register value is clamped to 1..FRAMES.
    always_comb begin
        cfg_wide = CMP_W'(r_cfg);
        if (r_cfg == '0) begin
            active = CNT_W'(1);
        end else if (cfg_wide > CMP_W'(FRAMES)) begin
            active = CNT_W'(FRAMES);
        end else begin
            active = CNT_W'(cfg_wide);
        end
    end

    // Frames below the fill count are the valid ones.
    assign scan_lim   = (r_fill < active) ? r_fill : active;
    assign hand_inc   = (CNT_W'(r_hand) + CNT_W'(1) == active) ? '0 : r_hand + FIDX_W'(1);
    assign misses_inc = (r_misses == MISS_MAX) ? r_misses : r_misses + MISS_W'(1);

    assign o_sts.match     = r_cmp_vld && (r_rd_data == r_page);
    assign o_sts.scan_end  = !r_cmp_vld && (r_scan >= scan_lim);
    assign o_sts.fill_room = r_fill < active;
    assign o_sts.ref_set   = r_ref[r_hand];

    assign rd_en   = (i_cmd.scan && (r_scan < scan_lim)) || i_cmd.victim_read;
    assign rd_addr = i_cmd.victim_read ? r_hand : r_scan[FIDX_W-1:0];
    assign wr_en   = i_cmd.fill_commit || i_cmd.evict_commit;
    assign wr_addr = i_cmd.evict_commit ? r_hand : r_fill[FIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= CFG_RESET;
            r_ref     <= '0;
            r_fill    <= '0;
            r_hand    <= '0;
            r_misses  <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_page    <= PAGE_BITS'(i_page_number);
                r_scan    <= '0;
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_scan < scan_lim) begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_scan[FIDX_W-1:0];
                    r_scan    <= r_scan + CNT_W'(1);
                end else begin
                    r_cmp_vld <= 1'b0;
                end
            end
            if (i_cmd.hit_commit) begin
                r_ref[r_cmp_idx] <= 1'b1;
                r_res_hit        <= 1'b1;
                r_res_idx        <= r_cmp_idx;
                r_res_ev         <= 1'b0;
                r_res_evp        <= '0;
            end
            if (i_cmd.fill_commit) begin
                r_ref[r_fill[FIDX_W-1:0]] <= 1'b1;
                r_fill    <= r_fill + CNT_W'(1);
                r_misses  <= misses_inc;
                r_res_hit <= 1'b0;
                r_res_idx <= r_fill[FIDX_W-1:0];
                r_res_ev  <= 1'b0;
                r_res_evp <= '0;
            end
            if (i_cmd.sweep_start) begin
                if (CNT_W'(r_hand) >= active) begin
                    r_hand <= '0;
                end
            end
            if (i_cmd.sweep) begin
                r_ref[r_hand] <= 1'b0;
                r_hand        <= hand_inc;
            end
            if (i_cmd.evict_commit) begin
                r_ref[r_hand] <= 1'b1;
                r_hand        <= hand_inc;
                r_misses      <= misses_inc;
                r_res_hit     <= 1'b0;
                r_res_idx     <= r_hand;
                r_res_ev      <= 1'b1;
                r_res_evp     <= r_rd_data;
            end
        end
    end

    // Output register; holds its beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_hit  <= r_res_hit;
            r_o_idx  <= IDX_W'(r_res_idx);
            r_o_ev   <= r_res_ev;
            r_o_evp  <= PAGE_W'(r_res_evp);
            r_o_miss <= r_misses;
        end
    end

    assign o_cfg           = r_cfg;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_idx;
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_page  = r_o_evp;
    assign o_miss_count    = r_o_miss;

endmodule

// ===== src/scpr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the second-chance page replacer: sequences lookup, fill,
// clock sweep and eviction, and owns both handshakes. Uses scpr_pkg.
module scpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output scpr_pkg::t_dp_cmd o_cmd,
    input  scpr_pkg::t_dp_sts i_sts
);
    import scpr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_EVICT,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.match) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = ST_DONE;
                end else if (i_sts.scan_end) begin
                    if (i_sts.fill_room) begin
                        o_cmd.fill_commit = 1'b1;
                        n_state           = ST_DONE;
                    end else begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = ST_SWEEP;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_SWEEP: begin
                // Frames with a set bit get their second chance here.
                if (i_sts.ref_set) begin
                    o_cmd.sweep = 1'b1;
                end else begin
                    o_cmd.victim_read = 1'b1;
                    n_state           = ST_EVICT;
                end
            end
            ST_EVICT: begin
                o_cmd.evict_commit = 1'b1;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== src/second_chance_page_replacer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the second-chance page replacer: configuration port decode and
// the controller and datapath. Depends on scpr_pkg, scpr_ctrl and scpr_datapath.
//
// Usage:
// - Input channel (i_valid / o_ready) takes one page reference per beat.
// - Output channel (o_valid / i_ready) returns one beat per reference: hit flag,
//   frame index, evicted flag and page, and the saturating miss count.
// - The APB-style port holds frames_in_use at address 0; write it only while idle.
// - The lookup reads the frame page memory one frame per cycle until it finds a
//   hit or has compared every filled managed frame; a miss then fills a free
//   frame. A replacement adds the clock sweep, which clears the reference bit
//   of each frame it passes (at most frames_in_use of them), then reads the
//   victim and writes the new page in its place.
// - One reference is processed at a time; o_ready is high only when the block
//   is idle. The output register lets the next beat be accepted while the last
//   result is still waiting; a stalled receiver holds the finished result in
//   the last state until the output register frees up.
// - Reset empties all frames, clears reference bits, the clock hand and the
//   miss count, and sets frames_in_use to 16. No clearing pass is needed.
module second_chance_page_replacer_unit #(
    parameter int unsigned FRAMES    = 16,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpr_pkg::APB_AW-1:0]   paddr,
    input  logic [scpr_pkg::APB_DW-1:0]   pwdata,
    output logic [scpr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [scpr_pkg::PAGE_W-1:0]   i_page_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [scpr_pkg::IDX_W-1:0]    o_frame_index,
    output logic                          o_evicted_valid,
    output logic [scpr_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [scpr_pkg::MISS_W-1:0]   o_miss_count
);
    import scpr_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg;
    logic             unused_paddr;

    // Only one register exists, so every address inside the port maps to it.
    assign pready       = 1'b1;
    assign cfg_we       = psel && penable && pwrite && pready;
    assign unused_paddr = ^paddr;
    assign prdata       = unused_paddr ? APB_DW'(cfg) : APB_DW'(cfg);

    scpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    scpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (pwdata[CFG_W-1:0]),
        .o_cfg           (cfg),
        .i_page_number   (i_page_number),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_miss_count    (o_miss_count)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for second_chance_page_replacer_unit: a scoreboard class
// predicts each reference beat, plain tasks drive the stream and APB ports.
// Depends on scpr_pkg and the RTL of the replacer only.
module tb;
    import scpr_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int QUIET_LIMIT    = 5000;
    localparam int IDLE_HEAVY     = 87;
    localparam int IDLE_BOTH      = 30;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int MAX_FRAMES     = 16;
    localparam int REG_FRAMES_IN_USE = 0;
    localparam logic [APB_AW-1:0] FRAMES_ADDR = APB_AW'(4 * REG_FRAMES_IN_USE);

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [MISS_W-1:0] miss_count;
    } t_page_result;

    class page_replacer_scoreboard;
        logic [PAGE_W-1:0] frame_page[MAX_FRAMES];
        bit                frame_valid[MAX_FRAMES];
        bit                ref_bit[MAX_FRAMES];
        int unsigned       fill_count;
        int unsigned       hand;
        logic [CFG_W-1:0]  frames_reg;
        logic [MISS_W-1:0] misses;
        t_page_result      expected_results[$];

        function new();
            for (int i = 0; i < MAX_FRAMES; i++) begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                ref_bit[i]     = 1'b0;
            end
            fill_count = 0;
            hand       = 0;
            frames_reg = CFG_RESET;
            misses     = '0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_reg = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Lookup, fill or clock sweep for one accepted reference.
        function void note_page(logic [PAGE_W-1:0] page);
            int unsigned  active;
            int unsigned  idx;
            int unsigned  h;
            int unsigned  steps;
            bit           found;
            t_page_result want;
            active = frames_reg;
            if (active < 1) active = 1;
            if (active > MAX_FRAMES) active = MAX_FRAMES;
            found = 1'b0;
            idx   = 0;
            want  = '0;
            for (int i = 0; i < active; i++) begin
                if (!found && frame_valid[i] && frame_page[i] == page) begin
                    found = 1'b1;
                    idx   = i;
                end
            end
            if (found) begin
                want.hit     = 1'b1;
                ref_bit[idx] = 1'b1;
            end else begin
                if (misses != MISS_MAX) misses++;
                if (fill_count < active) begin
                    idx = fill_count;
                    fill_count++;
                end else begin
                    h = (hand >= active) ? 0 : hand;
                    for (steps = 0; steps < 2 * active && ref_bit[h]; steps++) begin
                        ref_bit[h] = 1'b0;
                        h = (h + 1) % active;
                    end
                    idx = h;
                    want.evicted_valid = 1'b1;
                    want.evicted_page  = frame_page[idx];
                    hand = (idx + 1) % active;
                end
                frame_page[idx]  = page;
                frame_valid[idx] = 1'b1;
                ref_bit[idx]     = 1'b1;
            end
            want.frame_index = idx[IDX_W-1:0];
            want.miss_count  = misses;
            expected_results.push_back(want);
        endfunction

        // Returns an empty string when the beat matches the oldest prediction.
        function string check_result(t_page_result got);
            t_page_result want;
            string        msg;
            if (expected_results.size() == 0)
                return $sformatf("result beat with nothing pending: frame %0d miss_count %0d",
                                 got.frame_index, got.miss_count);
            want = expected_results.pop_front();
            msg  = "";
            if (got.hit !== want.hit)
                msg = {msg, $sformatf(" hit %b/%b", got.hit, want.hit)};
            if (got.frame_index !== want.frame_index)
                msg = {msg, $sformatf(" frame_index %0d/%0d", got.frame_index, want.frame_index)};
            if (got.evicted_valid !== want.evicted_valid)
                msg = {msg, $sformatf(" evicted_valid %b/%b", got.evicted_valid,
                                      want.evicted_valid)};
            if (got.evicted_page !== want.evicted_page)
                msg = {msg, $sformatf(" evicted_page %h/%h", got.evicted_page, want.evicted_page)};
            if (got.miss_count !== want.miss_count)
                msg = {msg, $sformatf(" miss_count %0d/%0d", got.miss_count, want.miss_count)};
            if (msg != "") msg = {"result mismatch (got/exp):", msg};
            return msg;
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic [PAGE_W-1:0]   i_page_number;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_hit;
    logic [IDX_W-1:0]    o_frame_index;
    logic                o_evicted_valid;
    logic [PAGE_W-1:0]   o_evicted_page;
    logic [MISS_W-1:0]   o_miss_count;

    page_replacer_scoreboard sb;
    int          mismatches = 0;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        squeeze_req;
    logic        squeeze_seen = 1'b0;
    int          squeeze_left = 0;
    logic [PAGE_W-1:0] page_pool[24];

    second_chance_page_replacer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_miss_count    (o_miss_count)
    );

    always #CLK_HALF i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (squeeze_req != squeeze_seen) begin
            squeeze_seen <= squeeze_req;
            squeeze_left <= SQUEEZE_CYCLES;
            i_ready      <= 1'b0;
        end else if (squeeze_left != 0) begin
            squeeze_left <= squeeze_left - 1;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_page_result got;
        string        msg;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_page(i_page_number);
            if (o_valid && i_ready) begin
                got.hit           = o_hit;
                got.frame_index   = o_frame_index;
                got.evicted_valid = o_evicted_valid;
                got.evicted_page  = o_evicted_page;
                got.miss_count    = o_miss_count;
                msg = sb.check_result(got);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("FAIL second_chance_page_replacer_unit");
        $finish;
    end

    // Offers one reference beat and returns at the edge that accepts it; valid stays
    // high so that a back-to-back beat needs no extra assignment.
    task automatic send_page(input logic [PAGE_W-1:0] page);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // The first edge lets the monitor note a beat accepted at the calling edge.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Setup and access phases for a write, then a read back of the same register.
    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAMES_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_frames(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== APB_DW'(value))
            report_mismatch($sformatf("frames_in_use read back %h, wrote %h", rd, value));
    endtask

    // Most references come from a working set a little larger than the managed
    // frames, so hits, sweeps and evictions all occur; the rest are arbitrary pages.
    task automatic run_phase(input logic [CFG_W-1:0] frames, input int send_pct,
                             input int recv_pct, input int count, input bit squeeze);
        int active;
        int pool_n;
        wait_idle();
        write_frames_in_use(frames);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
        active = (frames == 0) ? 1 : (frames > MAX_FRAMES) ? MAX_FRAMES : frames;
        pool_n = active + 1 + $urandom_range(0, 4);
        for (int k = 0; k < pool_n; k++) page_pool[k] = PAGE_W'($urandom_range(0, 65535));
        @(posedge i_clk);
        if (squeeze) squeeze_req <= ~squeeze_req;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0) send_page(PAGE_W'($urandom_range(0, 65535)));
            else send_page(page_pool[$urandom_range(0, pool_n - 1)]);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_page_number = '0;
        squeeze_req   = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill from empty with the field extremes and both checkerboards, then hit.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'h0000);
        send_page(16'hFFFF);
        // Shrinking the count below the filled frames forces a full sweep, and a
        // page resident above the count misses.
        wait_idle();
        write_frames_in_use(5'd2);
        send_page(16'h1234);
        send_page(16'h5555);
        // Zero acts as one frame.
        wait_idle();
        write_frames_in_use(5'd0);
        send_page(16'h7777);
        send_page(16'h7777);
        send_page(16'h0001);
        // An oversized value acts as the full frame count. The page is now held
        // twice, and the lower frame must win.
        wait_idle();
        write_frames_in_use(5'd31);
        send_page(16'h5555);
        for (int k = 0; k < 12; k++) send_page(16'h0100 + 16'(k));
        send_page(16'h4321);

        run_phase(5'd16, 0,          0,          35, 1'b0);
        run_phase(5'd1,  IDLE_HEAVY, 0,          35, 1'b0);
        run_phase(5'd5,  0,          IDLE_HEAVY, 35, 1'b0);
        run_phase(5'd17, IDLE_BOTH,  IDLE_BOTH,  35, 1'b0);
        run_phase(5'd12, 0,          0,          35, 1'b1);
        run_phase(5'd2,  IDLE_HEAVY, 0,          35, 1'b0);
        run_phase(5'd9,  0,          IDLE_HEAVY, 35, 1'b0);
        run_phase(5'd0,  IDLE_BOTH,  IDLE_BOTH,  35, 1'b0);
        run_phase(5'd16, IDLE_BOTH,  IDLE_BOTH,  35, 1'b0);
        run_phase(5'd3,  0,          0,          35, 1'b0);
        run_phase(5'd16, IDLE_BOTH, IDLE_BOTH, 30, 1'b0);

        wait_idle();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) $display("PASS second_chance_page_replacer_unit");
        else $display("FAIL second_chance_page_replacer_unit");
        $finish;
    end

endmodule

// ===== files.f =====
src/scpr_pkg.sv
src/scpr_datapath.sv
src/scpr_ctrl.sv
src/second_chance_page_replacer_unit.sv
verif/tb.sv
